// ----- hw/rtl/tcw_pkg.sv -----
`default_nettype none
package tcw_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int LAST_BASE  = (ROWS - 1) * COLUMNS;

  // internal widths
  localparam int IDX_W  = $clog2(CELL_COUNT);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COLT_W = $clog2(COLUMNS + 8);
  localparam int ROWT_W = $clog2(ROWS + 1);

  // port field widths
  localparam int CELL_W    = 16;
  localparam int ATTR_W    = 8;
  localparam int CHAR_W    = 8;
  localparam int FUNC_W    = 2;
  localparam int IN_IDX_W  = 11;
  localparam int OUT_IDX_W = 11;
  localparam int OUT_COL_W = 7;
  localparam int OUT_ROW_W = 5;

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] cursor_index;
    logic [OUT_COL_W-1:0] cursor_col;
    logic [OUT_ROW_W-1:0] cursor_row;
    logic [CELL_W-1:0]    cell_data;
  } result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tcw_ram.sv -----
`default_nettype none
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tcw_ctrl.sv -----
`default_nettype none
module tcw_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [tcw_pkg::ATTR_W-1:0]    attr,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [tcw_pkg::FUNC_W-1:0]    func,
  input  wire logic [tcw_pkg::CHAR_W-1:0]    character,
  input  wire logic [tcw_pkg::IN_IDX_W-1:0]  cell_index,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output tcw_pkg::result_t                   res
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_SCROLL_START, S_SCROLL, S_READ_WAIT, S_DONE
  } state_t;

  state_t               state;
  logic [IDX_W-1:0]     cnt;
  logic                 reset_pass;
  logic [COL_W-1:0]     col;
  logic [ROW_W-1:0]     row;
  logic [FUNC_W-1:0]    func_q;
  logic [CHAR_W-1:0]    char_q;
  logic [IN_IDX_W-1:0]  idx_q;
  logic [CELL_W-1:0]    data;

  // memory port
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [CELL_W-1:0]    mem_wdata;
  logic [IDX_W-1:0]     mem_raddr;
  logic [CELL_W-1:0]    mem_rdata;

  // cursor step for a put item
  logic [COLT_W-1:0]    col_t;
  logic [ROWT_W-1:0]    row_t;
  logic [COLT_W-1:0]    tab_sum;
  logic                 put_we;
  logic                 scroll;
  logic [COL_W-1:0]     new_col;
  logic [ROW_W-1:0]     new_row;

  logic [IDX_W-1:0]     cur_idx;
  logic [CELL_W-1:0]    blank;
  logic                 rd_in_range;
  logic [IDX_W:0]       next_src;
  logic                 last_cell;

  assign cur_idx     = IDX_W'(row) * IDX_W'(COLUMNS) + IDX_W'(col);
  assign blank       = {attr, CH_SPACE};
  assign rd_in_range = 32'(idx_q) < 32'(CELL_COUNT);
  assign next_src    = (IDX_W + 1)'(cnt) + (IDX_W + 1)'(1);
  assign last_cell   = cnt == IDX_W'(CELL_COUNT - 1);
  assign tab_sum     = COLT_W'(col) + COLT_W'(8);

  always_comb begin
    col_t  = COLT_W'(col);
    row_t  = ROWT_W'(row);
    put_we = 1'b0;
    if (char_q == CH_BS) begin
      if (col != '0) begin
        col_t = col_t - COLT_W'(1);
      end
    end else if (char_q == CH_TAB) begin
      col_t = {tab_sum[COLT_W-1:3], 3'b000};
    end else if (char_q == CH_CR) begin
      col_t = '0;
    end else if (char_q == CH_LF) begin
      col_t = '0;
      row_t = row_t + ROWT_W'(1);
    end else if (char_q >= CH_SPACE) begin
      put_we = 1'b1;
      col_t  = col_t + COLT_W'(1);
    end
    if (col_t >= COLT_W'(COLUMNS)) begin
      col_t = '0;
      row_t = row_t + ROWT_W'(1);
    end
    scroll  = row_t >= ROWT_W'(ROWS);
    new_row = scroll ? ROW_W'(ROWS - 1) : ROW_W'(row_t);
    new_col = COL_W'(col_t);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt;
    mem_wdata = blank;
    mem_raddr = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = reset_pass ? {RESET_ATTR, CH_SPACE} : blank;
      end
      S_EXEC: begin
        if (func_q == FUNC_PUT && put_we) begin
          mem_we    = 1'b1;
          mem_waddr = cur_idx;
          mem_wdata = {attr, char_q};
        end
        if (func_q == FUNC_READ && rd_in_range) begin
          mem_raddr = IDX_W'(idx_q);
        end
      end
      S_SCROLL_START: begin
        mem_raddr = IDX_W'(COLUMNS);
      end
      S_SCROLL: begin
        mem_we    = 1'b1;
        mem_wdata = (cnt < IDX_W'(LAST_BASE)) ? mem_rdata : blank;
        if (next_src < (IDX_W + 1)'(LAST_BASE)) begin
          mem_raddr = IDX_W'(next_src + (IDX_W + 1)'(COLUMNS));
        end
      end
      default: begin
      end
    endcase
  end

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELL_COUNT)
  ) u_cells (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cnt        <= '0;
      reset_pass <= 1'b1;
      col        <= '0;
      row        <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + IDX_W'(1);
          if (last_cell) begin
            cnt        <= '0;
            reset_pass <= 1'b0;
            state      <= reset_pass ? S_IDLE : S_DONE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            func_q <= func;
            char_q <= character;
            idx_q  <= cell_index;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          data <= '0;
          unique case (func_q)
            FUNC_PUT: begin
              col   <= new_col;
              row   <= new_row;
              state <= scroll ? S_SCROLL_START : S_DONE;
            end
            FUNC_CLEAR: begin
              col   <= '0;
              row   <= '0;
              cnt   <= '0;
              state <= S_CLEAR;
            end
            FUNC_READ: begin
              state <= S_READ_WAIT;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_SCROLL_START: begin
          cnt   <= '0;
          state <= S_SCROLL;
        end
        S_SCROLL: begin
          cnt <= cnt + IDX_W'(1);
          if (last_cell) begin
            cnt   <= '0;
            state <= S_DONE;
          end
        end
        S_READ_WAIT: begin
          data  <= rd_in_range ? mem_rdata : '0;
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready         = state == S_IDLE;
  assign res_valid        = state == S_DONE;
  assign res.cursor_index = OUT_IDX_W'(cur_idx);
  assign res.cursor_col   = OUT_COL_W'(col);
  assign res.cursor_row   = OUT_ROW_W'(row);
  assign res.cell_data    = data;

endmodule
`default_nettype wire

// ----- hw/rtl/text_console_writer.sv -----
// text console writer over a COLUMNS x ROWS cell store, one word in, one word out;
// each word passes through S_EXEC, then S_READ_WAIT for a read, S_SCROLL_START and
// S_SCROLL for a put that scrolls, or S_CLEAR for a clear, then S_DONE and the output
// register; one word at a time: the next word is taken only once the reply has left
// S_DONE for the output register, so a stalled output word can hold the input back
// reset: synchronous, homes the cursor, attribute 0x0F, then a clearing pass writes
// blanks to all CELL_COUNT cells (2000 at 80x25) while no input word is taken
`default_nettype none
module text_console_writer (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration write
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tcw_pkg::ATTR_W-1:0]     attribute,
  // input words
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [tcw_pkg::FUNC_W-1:0]     func,
  input  wire logic [tcw_pkg::CHAR_W-1:0]     character,
  input  wire logic [tcw_pkg::IN_IDX_W-1:0]   cell_index,
  // output words
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [tcw_pkg::OUT_IDX_W-1:0]       cursor_index,
  output logic [tcw_pkg::OUT_COL_W-1:0]       cursor_col,
  output logic [tcw_pkg::OUT_ROW_W-1:0]       cursor_row,
  output logic [tcw_pkg::CELL_W-1:0]          cell_data
);
  import tcw_pkg::*;

  logic [ATTR_W-1:0] attr;       // current attribute byte
  logic              res_valid;  // sequencer has a finished word
  logic              res_ready;  // output register can take it
  result_t           res;

  // attribute register, takes a write on any cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= RESET_ATTR;
    end else if (cfg_valid) begin
      attr <= attribute;
    end
  end

  // sequencer with the cell memory and the cursor
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .attr      (attr),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .character (character),
    .cell_index(cell_index),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: frees the sequencer so the next word can be taken
  // while this one waits downstream
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (res_valid && res_ready) begin
      cursor_index <= res.cursor_index;
      cursor_col   <= res.cursor_col;
      cursor_row   <= res.cursor_row;
      cell_data    <= res.cell_data;
    end
  end

  // the clearing pass after reset keeps the input closed
  a_reset_closed: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input open during clearing pass");

  // one item at a time: an accepted word closes the input
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // reported cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(cursor_col) < 32'(COLUMNS)) && (32'(cursor_row) < 32'(ROWS)))
    else $error("cursor off screen");

  // linear cursor agrees with row and column
  a_cursor_index: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cursor_index ==
      OUT_IDX_W'(32'(cursor_row) * COLUMNS + 32'(cursor_col)))
    else $error("cursor index mismatch");

endmodule
`default_nettype wire

// ----- tb/text_console_writer_tb.sv -----
`default_nettype none
module text_console_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  // the fourth function code has no name in the package; the block must ignore it
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

  // a clear or a scroll sweeps the whole store, the reset clearing pass too,
  // so the quiet-cycle limit is several such sweeps plus the longest stall
  localparam int WATCHDOG_LIMIT = 25000;
  // a few idle cycles after the last reply before touching the register
  localparam int SETTLE_CYCLES  = 8;
  localparam int SEGMENTS       = 6;
  localparam int SEGMENT_WORDS  = 75;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [ATTR_W-1:0]     attribute = '0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [FUNC_W-1:0]     func = '0;
  logic [CHAR_W-1:0]     character = '0;
  logic [IN_IDX_W-1:0]   cell_index = '0;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OUT_IDX_W-1:0]  cursor_index;
  logic [OUT_COL_W-1:0]  cursor_col;
  logic [OUT_ROW_W-1:0]  cursor_row;
  logic [CELL_W-1:0]     cell_data;

  // shadow of the console: cell store, cursor and attribute register
  logic [CELL_W-1:0]     screen_model [CELL_COUNT];
  int                    cur_col;
  int                    cur_row;
  logic [ATTR_W-1:0]     attr_model;

  // words predicted at input accept, oldest first
  result_t               console_replies [$];

  int                    mismatch_count = 0;
  int                    word_count = 0;
  int                    quiet_cycles = 0;
  int                    ready_left = 0;
  bit                    bursts_off = 1'b0;

  text_console_writer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .attribute    (attribute),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .character    (character),
    .cell_index   (cell_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cursor_index (cursor_index),
    .cursor_col   (cursor_col),
    .cursor_row   (cursor_row),
    .cell_data    (cell_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // console shadow
  // ---------------------------------------------------------------------------

  function automatic logic [CELL_W-1:0] blank_word();
    return {attr_model, CH_SPACE};
  endfunction

  function automatic void home_console();
    for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = blank_word();
    cur_col = 0;
    cur_row = 0;
  endfunction

  // move the store up one row once the cursor falls off the bottom
  function automatic void scroll_console();
    if (cur_row >= ROWS) begin
      for (int i = 0; i < LAST_BASE; i++) screen_model[i] = screen_model[i + COLUMNS];
      for (int i = LAST_BASE; i < CELL_COUNT; i++) screen_model[i] = blank_word();
      cur_row = ROWS - 1;
    end
  endfunction

  function automatic void put_console(input logic [CHAR_W-1:0] ch);
    if (ch == CH_BS) begin
      if (cur_col != 0) cur_col--;
    end else if (ch == CH_TAB) begin
      cur_col = (cur_col + 8) & ~7;
    end else if (ch == CH_CR) begin
      cur_col = 0;
    end else if (ch == CH_LF) begin
      cur_col = 0;
      cur_row++;
    end else if (ch >= CH_SPACE) begin
      screen_model[cur_row * COLUMNS + cur_col] = {attr_model, ch};
      cur_col++;
    end
    // other control codes leave everything alone
    if (cur_col >= COLUMNS) begin
      cur_col = 0;
      cur_row++;
    end
    scroll_console();
  endfunction

  // apply one accepted word and return the reply it must produce
  function automatic result_t advance_console(input logic [FUNC_W-1:0] f,
                                              input logic [CHAR_W-1:0] ch,
                                              input logic [IN_IDX_W-1:0] ci);
    result_t r;
    r.cell_data = '0;
    if (f == FUNC_PUT) begin
      put_console(ch);
    end else if (f == FUNC_CLEAR) begin
      home_console();
    end else if (f == FUNC_READ) begin
      if (ci < CELL_COUNT) r.cell_data = screen_model[ci];
    end
    r.cursor_index = OUT_IDX_W'(cur_row * COLUMNS + cur_col);
    r.cursor_col   = OUT_COL_W'(cur_col);
    r.cursor_row   = OUT_ROW_W'(cur_row);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [CELL_W-1:0] got,
                                 input logic [CELL_W-1:0] want);
    mismatch_count++;
    $display("mismatch on reply %0d: %s got %0h want %0h", word_count, what, got, want);
  endtask

  // every reply taken at a rising edge is held against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (out_valid && out_ready) begin
      if (console_replies.size() == 0) begin
        report_mismatch("unexpected word", cell_data, '0);
      end else begin
        want = console_replies.pop_front();
        if (cursor_index !== want.cursor_index)
          report_mismatch("cursor_index", CELL_W'(cursor_index), CELL_W'(want.cursor_index));
        if (cursor_col !== want.cursor_col)
          report_mismatch("cursor_col", CELL_W'(cursor_col), CELL_W'(want.cursor_col));
        if (cursor_row !== want.cursor_row)
          report_mismatch("cursor_row", CELL_W'(cursor_row), CELL_W'(want.cursor_row));
        if (cell_data !== want.cell_data)
          report_mismatch("cell_data", cell_data, want.cell_data);
      end
      word_count++;
    end
  end

  // watchdog: any accept on any channel restarts the count
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver back-pressure: random bursts of stall or ready
  always @(negedge clk) begin
    if (rst || bursts_off) begin
      out_ready <= 1'b1;
    end else if (ready_left > 0) begin
      ready_left--;
    end else begin
      out_ready  <= ($urandom_range(0, 3) != 0);
      ready_left = $urandom_range(0, 6);
    end
  end

  // ---------------------------------------------------------------------------
  // drivers; every task starts and ends on a falling edge
  // ---------------------------------------------------------------------------

  // offer one word, predict its reply at the accepting edge, then maybe idle;
  // valid is left high when the next word follows at once
  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] ch,
                           input logic [IN_IDX_W-1:0] ci);
    in_valid   <= 1'b1;
    func       <= f;
    character  <= ch;
    cell_index <= ci;
    do @(posedge clk); while (!in_ready);
    console_replies.push_back(advance_console(f, ch, ci));
    @(negedge clk);
    if (!bursts_off && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
  endtask

  task automatic put_word(input logic [CHAR_W-1:0] ch);
    send_word(FUNC_PUT, ch, IN_IDX_W'($urandom_range(0, 2047)));
  endtask

  task automatic read_word(input int ci);
    send_word(FUNC_READ, CHAR_W'($urandom_range(0, 255)), IN_IDX_W'(ci));
  endtask

  task automatic clear_word();
    send_word(FUNC_CLEAR, CHAR_W'($urandom_range(0, 255)),
              IN_IDX_W'($urandom_range(0, 2047)));
  endtask

  // stop offering words and wait until every predicted reply has come back
  task automatic drain_console();
    in_valid <= 1'b0;
    while (console_replies.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write, only ever issued with the block drained
  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    cfg_valid <= 1'b1;
    attribute <= value;
    do @(posedge clk); while (!cfg_ready);
    attr_model = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset contents, field extremes and each control code
  task automatic test_directed();
    read_word(0);
    read_word(CELL_COUNT - 1);
    read_word(2047);                 // index past the store reads zero
    send_word(FUNC_SPARE, 8'hFF, 11'h7FF);
    put_word(8'h41);
    put_word(8'hFF);
    put_word(CH_SPACE);
    read_word(1);
    put_word(CH_BS);
    put_word(CH_CR);
    put_word(CH_BS);                 // backspace at column 0 holds
    repeat (10) put_word(CH_TAB);    // last tab runs off the right edge
    put_word(CH_LF);
    put_word(8'h01);                 // ignored control code
    clear_word();
    read_word(0);
    drain_console();
  endtask

  // newline past the bottom, wrap on the last row, tab off the last row
  task automatic test_scroll();
    clear_word();
    put_word(8'h51);
    repeat (ROWS) put_word(CH_LF);
    read_word(0);
    read_word(LAST_BASE - COLUMNS);
    for (int i = 0; i < COLUMNS; i++) put_word(CHAR_W'(8'h61 + (i % 26)));
    read_word(LAST_BASE - COLUMNS);
    read_word(LAST_BASE - 1);
    read_word(LAST_BASE);
    repeat (10) put_word(CH_TAB);
    read_word(LAST_BASE - COLUMNS + 5);
    drain_console();
  endtask

  // register extremes and one random value, seen in written and blank cells
  task automatic test_attributes();
    logic [ATTR_W-1:0] settings [3];
    settings[0] = 8'h00;
    settings[1] = 8'hFF;
    settings[2] = ATTR_W'($urandom_range(1, 254));
    foreach (settings[k]) begin
      write_attribute(settings[k]);
      clear_word();
      put_word(8'h7E);
      put_word(8'h80);
      put_word(8'hC3);
      for (int i = 0; i < 3; i++) read_word(i);
      read_word(CELL_COUNT - 1);
      repeat (ROWS) put_word(CH_LF);
      read_word(LAST_BASE);
      read_word(LAST_BASE - COLUMNS);
      drain_console();
    end
  endtask

  // mostly printable text with some control codes, reads near the cursor,
  // and a little noise: clears, the spare function, reads anywhere
  task automatic random_word();
    int kind;
    int spot;
    logic [CHAR_W-1:0] ch;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      put_word(CHAR_W'($urandom_range(CH_SPACE, 255)));
    end else if (kind < 68) begin
      case ($urandom_range(0, 5))
        0:       ch = CH_BS;
        1:       ch = CH_TAB;
        2:       ch = CH_CR;
        3, 4:    ch = CH_LF;
        default: ch = CHAR_W'($urandom_range(0, CH_SPACE - 1));
      endcase
      put_word(ch);
    end else if (kind < 92) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          spot = cur_row * COLUMNS + cur_col - $urandom_range(0, 100);
          read_word(spot < 0 ? 0 : spot);
        end
        2:       read_word($urandom_range(0, 2047));
        default: read_word($urandom_range(0, CELL_COUNT - 1));
      endcase
    end else if (kind < 96) begin
      send_word(FUNC_SPARE, CHAR_W'($urandom_range(0, 255)),
                IN_IDX_W'($urandom_range(0, 2047)));
    end else begin
      clear_word();
    end
  endtask

  // segments of random traffic, a new attribute between segments,
  // the last segment without any idling
  task automatic test_random();
    for (int s = 0; s < SEGMENTS; s++) begin
      case ($urandom_range(0, 3))
        0:       write_attribute(8'h00);
        1:       write_attribute(8'hFF);
        default: write_attribute(ATTR_W'($urandom_range(0, 255)));
      endcase
      if (s == SEGMENTS - 1) bursts_off = 1'b1;
      repeat (SEGMENT_WORDS) random_word();
      drain_console();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    attr_model = RESET_ATTR;
    home_console();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    // the block's clearing pass holds off input words; the first word waits it out
    test_directed();
    test_scroll();
    test_attributes();
    test_random();
    drain_console();
    if (mismatch_count == 0 && console_replies.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
